/* sv/drd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drd_pkg
// shared types and constants of the detection row decoder
// ----------------------------------------------------------------------------
package drd_pkg;

	// default sizes of a detection row
	localparam int DEF_MAX_CLASSES        = 128;
	localparam int DEF_FIRST_SCORE_COLUMN = 5;
	localparam int BOX_COLUMNS            = 4;
	localparam int Q_SHIFT                = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_IDX_FRAME_WIDTH     = 2'd0;
	localparam logic [1:0] CFG_IDX_FRAME_HEIGHT    = 2'd1;
	localparam logic [1:0] CFG_IDX_SCORE_THRESHOLD = 2'd2;

	// configuration reset values
	localparam logic [12:0] RST_FRAME_WIDTH     = 13'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT    = 13'd640;
	localparam logic [16:0] RST_SCORE_THRESHOLD = 17'd32768;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [16:0] score_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [23:0] element_value;
		logic               row_end;
	} elem_t;

	typedef struct packed {
		logic [6:0]         class_index;
		logic signed [23:0] best_score;
		logic [14:0]        box_left;
		logic [14:0]        box_top;
		logic signed [15:0] box_width;
		logic signed [15:0] box_height;
	} det_t;

	// finished row handed from the row tracker to the box unit
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] w;
		logic signed [23:0] h;
		logic signed [23:0] best;
		logic [6:0]         best_idx;
	} row_snap_t;

endpackage : drd_pkg
`default_nettype wire

/* sv/drd_row_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drd_row_track
// per-row column count, box capture and running best score; registers the
// finished row when both frame sizes are nonzero and it passes the threshold
// ----------------------------------------------------------------------------
module drd_row_track #(
	parameter int MAX_CLASSES        = drd_pkg::DEF_MAX_CLASSES,
	parameter int FIRST_SCORE_COLUMN = drd_pkg::DEF_FIRST_SCORE_COLUMN
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  drd_pkg::cfg_t       cfg,
	input  wire                 elem_valid,
	output logic                elem_ready,
	input  drd_pkg::elem_t      elem,
	output logic                snap_valid,
	input  wire                 snap_ready,
	output drd_pkg::row_snap_t  snap
);
	import drd_pkg::*;

	logic [7:0]         col_q;
	logic signed [23:0] box_q [BOX_COLUMNS];
	logic signed [23:0] best_q;
	logic [6:0]         best_idx_q;
	logic               have_q;

	logic signed [23:0] box_n [BOX_COLUMNS];
	logic signed [23:0] best_n;
	logic [6:0]         best_idx_n;
	logic               have_n;
	logic [7:0]         col_n;
	logic               in_range;
	logic [7:0]         k;
	logic               take;
	logic               emit;
	logic               accept;

	logic               valid_s1;
	row_snap_t          snap_s1;

	assign accept     = elem_valid && elem_ready;
	assign elem_ready = !valid_s1 || snap_ready;
	assign snap_valid = valid_s1;
	assign snap       = snap_s1;

	always_comb begin
		in_range = (col_q != 8'd255);
		for (int i = 0; i < BOX_COLUMNS; i++) begin
			box_n[i] = (in_range && col_q == 8'(i)) ? elem.element_value : box_q[i];
		end
		k    = col_q - 8'(FIRST_SCORE_COLUMN);
		take = in_range && (col_q >= 8'(FIRST_SCORE_COLUMN)) && (k < 8'(MAX_CLASSES))
			&& (!have_q || elem.element_value > best_q);
		best_n     = take ? elem.element_value : best_q;
		best_idx_n = take ? k[6:0] : best_idx_q;
		have_n     = have_q || take;
		col_n      = in_range ? col_q + 8'd1 : col_q;
		emit = have_n && (cfg.frame_width != 13'd0) && (cfg.frame_height != 13'd0)
			&& ($signed({best_n[23], best_n}) > $signed({8'd0, cfg.score_threshold}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= 8'd0;
			best_q     <= '0;
			best_idx_q <= 7'd0;
			have_q     <= 1'b0;
			for (int i = 0; i < BOX_COLUMNS; i++) begin
				box_q[i] <= '0;
			end
		end else if (accept) begin
			if (elem.row_end) begin
				col_q      <= 8'd0;
				best_q     <= '0;
				best_idx_q <= 7'd0;
				have_q     <= 1'b0;
				for (int i = 0; i < BOX_COLUMNS; i++) begin
					box_q[i] <= '0;
				end
			end else begin
				col_q      <= col_n;
				best_q     <= best_n;
				best_idx_q <= best_idx_n;
				have_q     <= have_n;
				for (int i = 0; i < BOX_COLUMNS; i++) begin
					box_q[i] <= box_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && elem.row_end && emit) begin
			valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && elem.row_end && emit) begin
			snap_s1.cx       <= box_n[0];
			snap_s1.cy       <= box_n[1];
			snap_s1.w        <= box_n[2];
			snap_s1.h        <= box_n[3];
			snap_s1.best     <= best_n;
			snap_s1.best_idx <= best_idx_n;
		end
	end

endmodule : drd_row_track
`default_nettype wire

/* sv/drd_box_calc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drd_box_calc
// scales the box to pixels, clamps it to the frame and saturates it;
// multiply stage then clamp stage into the result register
// ----------------------------------------------------------------------------
module drd_box_calc (
	input  wire                 clk,
	input  wire                 arst_n,
	input  drd_pkg::cfg_t       cfg,
	input  wire                 snap_valid,
	output logic                snap_ready,
	input  drd_pkg::row_snap_t  snap,
	output logic                det_valid,
	input  wire                 det_ready,
	output drd_pkg::det_t       det
);
	import drd_pkg::*;

	// q8.16 times pixels, divided by 2^16 toward zero
	function automatic logic signed [21:0] scale_px(input logic signed [37:0] p);
		logic signed [37:0] adj;
		adj = p + ((p < 0) ? 38'sd65535 : 38'sd0);
		return adj[Q_SHIFT+21:Q_SHIFT];
	endfunction

	function automatic logic [14:0] sat_pos(input logic signed [22:0] v);
		return (v > 23'sd32767) ? 15'd32767 : v[14:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) r = 16'sd32767;
		else if (v < -24'sd32768) r = -16'sd32768;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [21:0] half_trunc(input logic signed [21:0] v);
		logic signed [21:0] a;
		a = v + $signed({21'd0, v[21]});
		return a >>> 1;
	endfunction

	logic               valid_s2;
	logic signed [37:0] pcx_s2, pcy_s2, pw_s2, ph_s2;
	logic signed [23:0] best_s2;
	logic [6:0]         idx_s2;
	logic               adv_out;
	logic               adv_s2;

	logic signed [21:0] cx, cy, w, h;
	logic signed [22:0] left0, top0, left1, top1;
	logic signed [23:0] fw, fh, w2, h2;
	det_t               det_n;

	assign adv_out    = !det_valid || det_ready;
	assign adv_s2     = !valid_s2 || adv_out;
	assign snap_ready = adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && snap_valid) begin
			pcx_s2  <= snap.cx * $signed({1'b0, cfg.frame_width});
			pcy_s2  <= snap.cy * $signed({1'b0, cfg.frame_height});
			pw_s2   <= snap.w * $signed({1'b0, cfg.frame_width});
			ph_s2   <= snap.h * $signed({1'b0, cfg.frame_height});
			best_s2 <= snap.best;
			idx_s2  <= snap.best_idx;
		end
	end

	always_comb begin
		cx    = scale_px(pcx_s2);
		cy    = scale_px(pcy_s2);
		w     = scale_px(pw_s2);
		h     = scale_px(ph_s2);
		fw    = $signed({11'd0, cfg.frame_width});
		fh    = $signed({11'd0, cfg.frame_height});
		left0 = 23'(cx) - 23'(half_trunc(w));
		top0  = 23'(cy) - 23'(half_trunc(h));
		left1 = (left0 < 0) ? 23'sd0 : left0;
		top1  = (top0 < 0) ? 23'sd0 : top0;
		w2    = (24'(left1) + 24'(w) >= fw) ? fw - 24'(left1) : 24'(w);
		h2    = (24'(top1) + 24'(h) >= fh) ? fh - 24'(top1) : 24'(h);
		det_n.class_index = idx_s2;
		det_n.best_score  = best_s2;
		det_n.box_left    = sat_pos(left1);
		det_n.box_top     = sat_pos(top1);
		det_n.box_width   = sat16(w2);
		det_n.box_height  = sat16(h2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_valid <= 1'b0;
		end else if (adv_out) begin
			det_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			det <= det_n;
		end
	end

endmodule : drd_box_calc
`default_nettype wire

/* sv/detection_row_decoder.sv */
`default_nettype none
// path: a row-end item that yields a result passes through the row register,
// the multiply stage and the result register
// throughput: one row element per cycle; the only stall is a full result
// pipeline held by det_ready low
// reset: arst_n low clears row state, pipeline valids and loads config defaults
// ----------------------------------------------------------------------------
// detection_row_decoder
// decodes one detector output row, streamed one element per item, into a
// scored pixel box of the best class
// ----------------------------------------------------------------------------
module detection_row_decoder #(
	parameter int MAX_CLASSES        = drd_pkg::DEF_MAX_CLASSES,
	parameter int FIRST_SCORE_COLUMN = drd_pkg::DEF_FIRST_SCORE_COLUMN
) (
	input  wire             clk,
	input  wire             arst_n,
	// configuration writes, taken whenever cfg_we is high
	input  wire             cfg_we,
	input  wire [1:0]       cfg_index,
	input  wire [16:0]      cfg_data,
	// row elements
	input  wire             elem_valid,
	output logic            elem_ready,
	input  drd_pkg::elem_t  elem,
	// detections
	output logic            det_valid,
	input  wire             det_ready,
	output drd_pkg::det_t   det
);
	import drd_pkg::*;

	cfg_t      cfg_q;
	logic      snap_valid;
	logic      snap_ready;
	row_snap_t snap;

	// configuration registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= RST_FRAME_WIDTH;
			cfg_q.frame_height    <= RST_FRAME_HEIGHT;
			cfg_q.score_threshold <= RST_SCORE_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data[12:0];
				CFG_IDX_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data[12:0];
				CFG_IDX_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// column count, box capture, running best; the finished row is
	// registered only when it carries a score above threshold and both frame sizes are nonzero
	drd_row_track #(
		.MAX_CLASSES        (MAX_CLASSES),
		.FIRST_SCORE_COLUMN (FIRST_SCORE_COLUMN)
	) u_row_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem       (elem),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// scale to pixels, clamp to frame, saturate into the result register
	drd_box_calc u_box_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.det_valid  (det_valid),
		.det_ready  (det_ready),
		.det        (det)
	);

endmodule : detection_row_decoder
`default_nettype wire
